### design/dpbc_pkg.sv
// Shared types, code points and level tables for the decoded picture buffer count block.
// No dependencies; compiled first.
`default_nettype none

package dpbc_pkg;

    // field widths
    localparam int unsigned STD_W    = 2;
    localparam int unsigned LVL_W    = 8;
    localparam int unsigned REORD_W  = 5;
    localparam int unsigned DIM_W    = 14;
    localparam int unsigned MINBUF_W = 6;
    localparam int unsigned VIEWS_W  = 5;
    localparam int unsigned NUM_W    = 7;
    localparam int unsigned STAT_W   = 2;

    // macroblock geometry
    localparam int unsigned MB_SIZE  = 16;
    localparam int unsigned MB_SHIFT = $clog2(MB_SIZE);
    localparam int unsigned MBD_W    = DIM_W + 1 - MB_SHIFT;   // macroblocks along one side
    localparam int unsigned MBS_W    = 2 * MBD_W;              // macroblocks per frame

    // divider chain: quotient only needs to reach the cap of 16
    localparam int unsigned QUO_W    = 5;
    localparam int unsigned DVD_W    = 18;                     // largest MaxDpbMbs entry
    localparam int unsigned CMP_W    = MBS_W + QUO_W - 1;

    localparam int unsigned SIZE_W   = 2 * DIM_W;              // luma samples per picture
    localparam int unsigned LIM_W    = 26;                     // largest MaxLumaPs entry
    localparam int unsigned HELD_W   = 6;

    localparam int unsigned HELD_CAP      = 16;
    localparam int unsigned HEVC_DPB_BASE = 6;
    localparam int unsigned HEVC_LEVEL_LO = 30;
    localparam int unsigned HEVC_LEVEL_HI = 186;
    localparam int unsigned COUNT_MAX     = 127;

    // codec standard codes
    localparam logic [STD_W-1:0] STD_H264 = 2'd0;
    localparam logic [STD_W-1:0] STD_HEVC = 2'd1;
    localparam logic [STD_W-1:0] STD_JPEG = 2'd2;
    localparam logic [STD_W-1:0] STD_NONE = 2'd3;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK          = 2'd0;
    localparam logic [STAT_W-1:0] ST_UNSUPPORTED = 2'd1;
    localparam logic [STAT_W-1:0] ST_BAD_MINOR   = 2'd2;
    localparam logic [STAT_W-1:0] ST_NO_LIMIT    = 2'd3;

    typedef struct packed {
        logic [STD_W-1:0]    std;
        logic [REORD_W-1:0]  reorder;
        logic [MINBUF_W-1:0] minbuf;
        logic [VIEWS_W-1:0]  views;
        logic                ilace;
        logic                hev_oor;     // HEVC level outside the table
        logic [STAT_W-1:0]   hev_status;
        logic [2:0]          hev_idx;
        logic [1:0]          hev_minor;
    } dpbc_hdr_t;

    typedef struct packed {
        dpbc_hdr_t           hdr;
        logic [SIZE_W-1:0]   size;
    } dpbc_tag_t;

    typedef struct packed {
        logic [DVD_W-1:0]    rem;
        logic [MBS_W-1:0]    dvs;
        logic [QUO_W-1:0]    quo;
    } dpbc_div_t;

    localparam logic [DVD_W-1:0] AVC_DPB_MBS [0:5][0:3] = '{
        '{18'd396,    18'd396,    18'd396,    18'd396},
        '{18'd396,    18'd900,    18'd2376,   18'd2376},
        '{18'd2376,   18'd4752,   18'd8100,   18'd8100},
        '{18'd8100,   18'd18000,  18'd20480,  18'd20480},
        '{18'd32768,  18'd32768,  18'd34816,  18'd34816},
        '{18'd110400, 18'd184320, 18'd184320, 18'd184320}
    };

    localparam logic [LIM_W-1:0] HEVC_LUMA_PS [0:5][0:2] = '{
        '{26'd36864,    26'd0,        26'd0},
        '{26'd122880,   26'd245760,   26'd0},
        '{26'd552960,   26'd983040,   26'd0},
        '{26'd2228224,  26'd2228224,  26'd0},
        '{26'd8912896,  26'd8912896,  26'd8912896},
        '{26'd35651584, 26'd35651584, 26'd35651584}
    };

    function automatic logic [DVD_W-1:0] avc_dpb_mbs(input logic [2:0] major,
                                                     input logic [1:0] minor);
        logic [DVD_W-1:0] v;
        v = '0;
        if (major <= 3'd5)
        begin
            v = AVC_DPB_MBS[major][minor];
        end
        return v;
    endfunction

    function automatic logic [LIM_W-1:0] hevc_luma_ps(input logic [2:0] idx,
                                                      input logic [1:0] minor);
        logic [LIM_W-1:0] v;
        v = '0;
        if (idx <= 3'd5 && minor <= 2'd2)
        begin
            v = HEVC_LUMA_PS[idx][minor];
        end
        return v;
    endfunction

endpackage

`default_nettype wire

### design/dpbc_if.sv
// Handshake channels of the block: header summary in, buffer count out.
// Depends on dpbc_pkg for field widths.
`default_nettype none

interface dpbc_hdr_if;
    import dpbc_pkg::*;
    logic                valid;
    logic                ready;
    logic [STD_W-1:0]    codec_std;
    logic [LVL_W-1:0]    level_idc;
    logic [REORD_W-1:0]  reorder_pictures;
    logic [DIM_W-1:0]    max_width;
    logic [DIM_W-1:0]    max_height;
    logic [DIM_W-1:0]    pic_width;
    logic [DIM_W-1:0]    pic_height;
    logic [MINBUF_W-1:0] min_buffers;
    logic [VIEWS_W-1:0]  view_count;
    logic                interlaced;

    modport source (output valid, codec_std, level_idc, reorder_pictures, max_width,
                    max_height, pic_width, pic_height, min_buffers, view_count,
                    interlaced, input ready);
    modport sink   (input valid, codec_std, level_idc, reorder_pictures, max_width,
                    max_height, pic_width, pic_height, min_buffers, view_count,
                    interlaced, output ready);
    modport mon    (input valid, ready, codec_std, level_idc, reorder_pictures,
                    max_width, max_height, pic_width, pic_height, min_buffers,
                    view_count, interlaced);
endinterface

interface dpbc_res_if;
    import dpbc_pkg::*;
    logic              valid;
    logic              ready;
    logic [NUM_W-1:0]  num_pictures;
    logic [STAT_W-1:0] status;

    modport source (output valid, num_pictures, status, input ready);
    modport sink   (input valid, num_pictures, status, output ready);
    modport mon    (input valid, ready, num_pictures, status);
endinterface

`default_nettype wire

### design/dpbc_front.sv
// Front end: level decode and table lookups, then the frame-size multiplies.
// Two pipeline stages. Depends on dpbc_pkg and dpbc_if.
`default_nettype none

module dpbc_front (
    input  wire logic             clk,
    input  wire logic             rst_n,
    dpbc_hdr_if.sink              hdr,
    output logic                  dn_valid,
    input  wire logic             dn_ready,
    output dpbc_pkg::dpbc_div_t   dn_div,
    output dpbc_pkg::dpbc_tag_t   dn_tag
);
    import dpbc_pkg::*;

    localparam int unsigned SUM_W = DIM_W + 1;

    logic               adv1;
    logic               adv2;

    logic [15:0]        lvl_x10;
    logic [4:0]         avc_major_raw;
    logic [LVL_W-1:0]   avc_minor_raw;
    logic [2:0]         avc_major;
    logic [1:0]         avc_minor;
    logic [15:0]        lvl_x30;
    logic [3:0]         hev_major;
    logic [LVL_W-1:0]   hev_rem;
    logic [SUM_W-1:0]   mbw_sum;
    logic [SUM_W-1:0]   mbh_sum;

    dpbc_hdr_t          s1_hdr_next;
    logic [DVD_W-1:0]   s1_dvd_next;
    logic [MBD_W-1:0]   s1_mbw_next;
    logic [MBD_W-1:0]   s1_mbh_next;

    logic               s1_v_reg;
    dpbc_hdr_t          s1_hdr_reg;
    logic [DVD_W-1:0]   s1_dvd_reg;
    logic [MBD_W-1:0]   s1_mbw_reg;
    logic [MBD_W-1:0]   s1_mbh_reg;
    logic [DIM_W-1:0]   s1_pw_reg;
    logic [DIM_W-1:0]   s1_ph_reg;

    logic [MBS_W-1:0]   s2_mbs_next;
    logic [SIZE_W-1:0]  s2_size_next;

    logic               s2_v_reg;
    dpbc_hdr_t          s2_hdr_reg;
    logic [DVD_W-1:0]   s2_dvd_reg;
    logic [MBS_W-1:0]   s2_mbs_reg;
    logic [SIZE_W-1:0]  s2_size_reg;

    assign adv2      = !s2_v_reg || dn_ready;
    assign adv1      = !s1_v_reg || adv2;
    assign hdr.ready = adv1;

    always_comb
    begin
        // level / 10 by reciprocal, exact for 8-bit values
        lvl_x10       = 16'(hdr.level_idc) * 16'd205;
        avc_major_raw = lvl_x10[15:11];
        avc_minor_raw = hdr.level_idc - (8'(avc_major_raw) * 8'd10);
        avc_major     = (avc_major_raw > 5'd5) ? 3'd5 : avc_major_raw[2:0];
        avc_minor     = (avc_minor_raw > 8'd3) ? 2'd3 : avc_minor_raw[1:0];

        // level / 30 by reciprocal, exact for 8-bit values
        lvl_x30   = 16'(hdr.level_idc) * 16'd137;
        hev_major = lvl_x30[15:12];
        hev_rem   = hdr.level_idc - (8'(hev_major) * 8'd30);

        s1_hdr_next.std     = hdr.codec_std;
        s1_hdr_next.reorder = hdr.reorder_pictures;
        s1_hdr_next.minbuf  = hdr.min_buffers;
        s1_hdr_next.views   = hdr.view_count;
        s1_hdr_next.ilace   = hdr.interlaced;
        s1_hdr_next.hev_oor = (hdr.level_idc < LVL_W'(HEVC_LEVEL_LO)) ||
                              (hdr.level_idc > LVL_W'(HEVC_LEVEL_HI));
        s1_hdr_next.hev_idx = 3'(hev_major - 4'd1);

        s1_hdr_next.hev_minor = 2'd0;
        if (hev_rem >= 8'd6)
        begin
            s1_hdr_next.hev_minor = 2'd2;
        end
        else if (hev_rem >= 8'd3)
        begin
            s1_hdr_next.hev_minor = 2'd1;
        end

        if (hev_rem >= 8'd9)
        begin
            s1_hdr_next.hev_status = ST_BAD_MINOR;
        end
        else if (hevc_luma_ps(s1_hdr_next.hev_idx, s1_hdr_next.hev_minor) == '0)
        begin
            s1_hdr_next.hev_status = ST_NO_LIMIT;
        end
        else
        begin
            s1_hdr_next.hev_status = ST_OK;
        end

        s1_dvd_next = avc_dpb_mbs(avc_major, avc_minor);

        mbw_sum     = SUM_W'(hdr.max_width) + SUM_W'(MB_SIZE - 1);
        mbh_sum     = SUM_W'(hdr.max_height) + SUM_W'(MB_SIZE - 1);
        s1_mbw_next = mbw_sum[SUM_W-1:MB_SHIFT];
        s1_mbh_next = mbh_sum[SUM_W-1:MB_SHIFT];
    end

    assign s2_mbs_next  = MBS_W'(s1_mbw_reg) * MBS_W'(s1_mbh_reg);
    assign s2_size_next = SIZE_W'(s1_pw_reg) * SIZE_W'(s1_ph_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
            begin
                s1_v_reg <= hdr.valid;
            end
            if (adv2)
            begin
                s2_v_reg <= s1_v_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1 && hdr.valid)
        begin
            s1_hdr_reg <= s1_hdr_next;
            s1_dvd_reg <= s1_dvd_next;
            s1_mbw_reg <= s1_mbw_next;
            s1_mbh_reg <= s1_mbh_next;
            s1_pw_reg  <= hdr.pic_width;
            s1_ph_reg  <= hdr.pic_height;
        end
        if (adv2 && s1_v_reg)
        begin
            s2_hdr_reg  <= s1_hdr_reg;
            s2_dvd_reg  <= s1_dvd_reg;
            s2_mbs_reg  <= s2_mbs_next;
            s2_size_reg <= s2_size_next;
        end
    end

    assign dn_valid    = s2_v_reg;
    assign dn_div.rem  = s2_dvd_reg;
    assign dn_div.dvs  = s2_mbs_reg;
    assign dn_div.quo  = '0;
    assign dn_tag.hdr  = s2_hdr_reg;
    assign dn_tag.size = s2_size_reg;

endmodule

`default_nettype wire

### design/dpbc_cell.sv
// One restoring-division cell: settles one quotient bit and passes the word on.
// Depends on dpbc_pkg.
`default_nettype none

module dpbc_cell #(
    parameter int unsigned SHIFT = 0
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 up_valid,
    output logic                      up_ready,
    input  wire dpbc_pkg::dpbc_div_t  up_div,
    input  wire dpbc_pkg::dpbc_tag_t  up_tag,
    output logic                      dn_valid,
    input  wire logic                 dn_ready,
    output dpbc_pkg::dpbc_div_t       dn_div,
    output dpbc_pkg::dpbc_tag_t       dn_tag
);
    import dpbc_pkg::*;

    logic               adv;
    logic [CMP_W-1:0]   trial;
    logic [CMP_W-1:0]   rem_ext;
    logic [CMP_W-1:0]   diff;
    logic               ge;
    dpbc_div_t          div_next;

    logic               v_reg;
    dpbc_div_t          div_reg;
    dpbc_tag_t          tag_reg;

    assign adv      = !v_reg || dn_ready;
    assign up_ready = adv;

    always_comb
    begin
        trial            = CMP_W'(up_div.dvs) << SHIFT;
        rem_ext          = CMP_W'(up_div.rem);
        ge               = rem_ext >= trial;
        diff             = rem_ext - trial;
        div_next.dvs     = up_div.dvs;
        div_next.rem     = ge ? diff[DVD_W-1:0] : up_div.rem;
        div_next.quo     = up_div.quo | (QUO_W'(ge) << SHIFT);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (adv)
        begin
            v_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && up_valid)
        begin
            div_reg <= div_next;
            tag_reg <= up_tag;
        end
    end

    assign dn_valid = v_reg;
    assign dn_div   = div_reg;
    assign dn_tag   = tag_reg;

endmodule

`default_nettype wire

### design/dpbc_back.sv
// Back end: picks the held count per standard, applies minimum, multiview and
// interlace adjustments, and holds the result word. Depends on dpbc_pkg, dpbc_if.
`default_nettype none

module dpbc_back (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 up_valid,
    output logic                      up_ready,
    input  wire dpbc_pkg::dpbc_div_t  up_div,
    input  wire dpbc_pkg::dpbc_tag_t  up_tag,
    dpbc_res_if.source                res
);
    import dpbc_pkg::*;

    logic                adv;
    logic [LIM_W-1:0]    limit;
    logic [SIZE_W-1:0]   lim_x;
    logic [SIZE_W-1:0]   lim_q1;
    logic [SIZE_W-1:0]   lim_q2;
    logic [SIZE_W-1:0]   lim_q3;
    logic [HELD_W-1:0]   avc_held;
    logic [HELD_W-1:0]   hev_held;
    logic [HELD_W-1:0]   held;
    logic [HELD_W-1:0]   floor_n;
    logic [8:0]          multi_n;
    logic [8:0]          total_n;
    logic [STAT_W-1:0]   status_next;
    logic [NUM_W-1:0]    num_next;

    logic                v_reg;
    logic [NUM_W-1:0]    num_reg;
    logic [STAT_W-1:0]   status_reg;

    assign adv      = !v_reg || res.ready;
    assign up_ready = adv;

    always_comb
    begin
        // quotient bit 4 set means at least 16 (also catches a zero divisor)
        if (up_tag.hdr.reorder != '0)
        begin
            avc_held = HELD_W'(up_tag.hdr.reorder);
        end
        else if (up_div.quo[QUO_W-1])
        begin
            avc_held = HELD_W'(HELD_CAP);
        end
        else
        begin
            avc_held = HELD_W'(up_div.quo[QUO_W-2:0]);
        end

        limit  = hevc_luma_ps(up_tag.hdr.hev_idx, up_tag.hdr.hev_minor);
        lim_x  = SIZE_W'(limit);
        lim_q1 = lim_x >> 2;
        lim_q2 = lim_x >> 1;
        lim_q3 = (lim_x + (lim_x << 1)) >> 2;
        if (up_tag.size <= lim_q1)
        begin
            hev_held = HELD_W'(HELD_CAP);
        end
        else if (up_tag.size <= lim_q2)
        begin
            hev_held = HELD_W'(2 * HEVC_DPB_BASE);
        end
        else if (up_tag.size <= lim_q3)
        begin
            hev_held = HELD_W'((4 * HEVC_DPB_BASE) / 3);
        end
        else
        begin
            hev_held = HELD_W'(HEVC_DPB_BASE);
        end

        held        = '0;
        status_next = ST_OK;
        case (up_tag.hdr.std)
            STD_H264:
            begin
                held = avc_held;
            end
            STD_HEVC:
            begin
                if (up_tag.hdr.hev_oor)
                begin
                    held = up_tag.hdr.minbuf;
                end
                else
                begin
                    held        = hev_held;
                    status_next = up_tag.hdr.hev_status;
                end
            end
            STD_JPEG:
            begin
                held = '0;
            end
            default:
            begin
                status_next = ST_UNSUPPORTED;
            end
        endcase

        floor_n = (held < up_tag.hdr.minbuf) ? up_tag.hdr.minbuf : held;
        if (up_tag.hdr.views > VIEWS_W'(1))
        begin
            multi_n = (9'(floor_n) << 1) + 9'(up_tag.hdr.views) - 9'd1;
        end
        else
        begin
            multi_n = 9'(floor_n);
        end
        total_n = multi_n + (up_tag.hdr.ilace ? 9'd2 : 9'd1);

        if (status_next != ST_OK)
        begin
            num_next = '0;
        end
        else if (total_n > 9'(COUNT_MAX))
        begin
            num_next = NUM_W'(COUNT_MAX);
        end
        else
        begin
            num_next = total_n[NUM_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (adv)
        begin
            v_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && up_valid)
        begin
            num_reg    <= num_next;
            status_reg <= status_next;
        end
    end

    assign res.valid        = v_reg;
    assign res.num_pictures = num_reg;
    assign res.status       = status_reg;

endmodule

`default_nettype wire

### design/decoded_picture_buffer_count.sv
// Registered path: two front stages, five divider cells, one output stage, in that order.
// Throughput: one word per cycle while the result channel is not stalled (res.ready high).
// Any stage whose word is taken onward (or that is empty) takes a new word, so gaps close up.
// Reset: rst_n asynchronous active low clears all stage valid bits; no clearing pass.
// Depends on dpbc_pkg, dpbc_if, dpbc_front, dpbc_cell, dpbc_back.
`default_nettype none

module decoded_picture_buffer_count (
    input  wire logic   clk,
    input  wire logic   rst_n,
    dpbc_hdr_if.sink    hdr,
    dpbc_res_if.source  res
);
    import dpbc_pkg::*;

    logic        lnk_valid [0:QUO_W];
    logic        lnk_ready [0:QUO_W];
    dpbc_div_t   lnk_div   [0:QUO_W];
    dpbc_tag_t   lnk_tag   [0:QUO_W];

    dpbc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .hdr      (hdr),
        .dn_valid (lnk_valid[0]),
        .dn_ready (lnk_ready[0]),
        .dn_div   (lnk_div[0]),
        .dn_tag   (lnk_tag[0])
    );

    // highest quotient bit first
    for (genvar i = 0; i < QUO_W; i++)
    begin : g_cell
        dpbc_cell #(
            .SHIFT (QUO_W - 1 - i)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (lnk_valid[i]),
            .up_ready (lnk_ready[i]),
            .up_div   (lnk_div[i]),
            .up_tag   (lnk_tag[i]),
            .dn_valid (lnk_valid[i+1]),
            .dn_ready (lnk_ready[i+1]),
            .dn_div   (lnk_div[i+1]),
            .dn_tag   (lnk_tag[i+1])
        );
    end

    dpbc_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (lnk_valid[QUO_W]),
        .up_ready (lnk_ready[QUO_W]),
        .up_div   (lnk_div[QUO_W]),
        .up_tag   (lnk_tag[QUO_W]),
        .res      (res)
    );

endmodule

`default_nettype wire

### design/dpbc_checker.sv
// Port-level checks for decoded_picture_buffer_count, attached by bind.
// Depends on dpbc_pkg and dpbc_if.
`default_nettype none

module dpbc_checker (
    input  wire logic   clk,
    input  wire logic   rst_n,
    dpbc_hdr_if.sink    hdr,
    dpbc_res_if.source  res
);
    import dpbc_pkg::*;

    localparam int unsigned DEPTH = QUO_W + 3;
    localparam int unsigned CNT_W = $clog2(DEPTH + 2);

    logic             hdr_acc;
    logic             res_acc;
    logic [CNT_W-1:0] inflight_reg;
    logic [CNT_W-1:0] inflight_next;

    assign hdr_acc = hdr.valid && hdr.ready;
    assign res_acc = res.valid && res.ready;

    always_comb
    begin
        inflight_next = inflight_reg;
        if (hdr_acc && !res_acc)
        begin
            inflight_next = inflight_reg + CNT_W'(1);
        end
        else if (!hdr_acc && res_acc)
        begin
            inflight_next = inflight_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= '0;
        end
        else
        begin
            inflight_reg <= inflight_next;
        end
    end

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && !res.ready |=> res.valid && $stable(res.num_pictures) &&
                                    $stable(res.status))
        else $error("result word changed while stalled");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.status != ST_OK |-> res.num_pictures == '0)
        else $error("error status with non-zero count");

    a_ok_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.status == ST_OK |-> res.num_pictures != '0)
        else $error("good result with zero buffers");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> inflight_reg != '0)
        else $error("result word with no header word outstanding");

    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg <= CNT_W'(DEPTH))
        else $error("more words in flight than pipeline stages");

endmodule

bind decoded_picture_buffer_count dpbc_checker u_dpbc_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .hdr   (hdr),
    .res   (res)
);

`default_nettype wire

### sim/dpbc_checker.sv
// Scoreboard for the decoded picture buffer count block: watches both channels,
// predicts the buffer count of every accepted header word and compares in order.
// Depends on dpbc_pkg and dpbc_if.
`default_nettype none

module dpbc_scoreboard (
    input  wire logic   clk,
    input  wire logic   rst_n,
    dpbc_hdr_if.mon     hdr,
    dpbc_res_if.mon     res,
    output int unsigned failures,
    output int unsigned answered,
    output int unsigned waiting,
    output logic [3:0]  status_seen
);
    import dpbc_pkg::*;

    typedef struct packed {
        logic [NUM_W-1:0]  num;
        logic [STAT_W-1:0] status;
    } dpb_answer_t;

    localparam int unsigned MB_PIXELS     = 16;
    localparam int unsigned DPB_CAP       = 16;
    localparam int unsigned DPB_HEVC_BASE = 6;
    localparam int unsigned HEVC_LVL_MIN  = 30;
    localparam int unsigned HEVC_LVL_MAX  = 186;
    localparam int unsigned COUNT_CEIL    = 127;
    localparam int unsigned REPORT_MAX    = 10;

    // MaxDpbMbs by [major][minor]
    localparam int unsigned AVC_MBS_TBL [0:5][0:3] = '{
        '{396,    396,    396,    396},
        '{396,    900,    2376,   2376},
        '{2376,   4752,   8100,   8100},
        '{8100,   18000,  20480,  20480},
        '{32768,  32768,  34816,  34816},
        '{110400, 184320, 184320, 184320}
    };

    // MaxLumaPs by [major-1][minor]; zero means no limit defined
    localparam int unsigned HEVC_LPS_TBL [0:5][0:2] = '{
        '{36864,    0,        0},
        '{122880,   245760,   0},
        '{552960,   983040,   0},
        '{2228224,  2228224,  0},
        '{8912896,  8912896,  8912896},
        '{35651584, 35651584, 35651584}
    };

    dpb_answer_t expected_q[$];
    int unsigned fault_total  = 0;
    int unsigned answer_total = 0;
    logic [3:0]  status_mask  = '0;

    function automatic dpb_answer_t predict_dpb(input logic [STD_W-1:0]    codec,
                                                input logic [LVL_W-1:0]    level,
                                                input logic [REORD_W-1:0]  reorder,
                                                input logic [DIM_W-1:0]    mw,
                                                input logic [DIM_W-1:0]    mh,
                                                input logic [DIM_W-1:0]    pw,
                                                input logic [DIM_W-1:0]    ph,
                                                input logic [MINBUF_W-1:0] minbuf,
                                                input logic [VIEWS_W-1:0]  views,
                                                input logic                ilace);
        int unsigned     held;
        int unsigned     major;
        int unsigned     minor;
        int unsigned     mbs;
        int unsigned     n;
        longint unsigned limit;
        longint unsigned area;
        dpb_answer_t     ans;
        held       = 0;
        ans.status = ST_OK;
        ans.num    = '0;
        if (codec == STD_H264)
        begin
            if (reorder != 0)
            begin
                held = reorder;
            end
            else
            begin
                major = level / 10;
                minor = level % 10;
                if (major > 5)
                    major = 5;
                if (minor > 3)
                    minor = 3;
                mbs = ((mw + MB_PIXELS - 1) / MB_PIXELS) *
                      ((mh + MB_PIXELS - 1) / MB_PIXELS);
                if (mbs == 0)
                    held = DPB_CAP;
                else
                begin
                    held = AVC_MBS_TBL[major][minor] / mbs;
                    if (held > DPB_CAP)
                        held = DPB_CAP;
                end
            end
        end
        else if (codec == STD_HEVC)
        begin
            if (level < HEVC_LVL_MIN || level > HEVC_LVL_MAX)
            begin
                held = minbuf;
            end
            else
            begin
                major = level / 30;
                minor = (level % 30) / 3;
                if (minor >= 3)
                    ans.status = ST_BAD_MINOR;
                else
                begin
                    limit = HEVC_LPS_TBL[major-1][minor];
                    area  = 64'(pw) * 64'(ph);
                    if (limit == 0)
                        ans.status = ST_NO_LIMIT;
                    else if (area <= (limit >> 2))
                        held = DPB_CAP;
                    else if (area <= (limit >> 1))
                        held = 2 * DPB_HEVC_BASE;
                    else if (area <= ((3 * limit) >> 2))
                        held = (4 * DPB_HEVC_BASE) / 3;
                    else
                        held = DPB_HEVC_BASE;
                end
            end
        end
        else if (codec == STD_JPEG)
        begin
            held = 0;
        end
        else
        begin
            ans.status = ST_UNSUPPORTED;
        end

        if (ans.status == ST_OK)
        begin
            n = (held < minbuf) ? minbuf : held;
            if (views > 1)
                n = 2 * n + (views - 1);
            n = n + (ilace ? 2 : 1);
            if (n > COUNT_CEIL)
                n = COUNT_CEIL;
            ans.num = NUM_W'(n);
        end
        return ans;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        dpb_answer_t want;
        if (!rst_n)
        begin
            expected_q.delete();
            fault_total  = 0;
            answer_total = 0;
            status_mask  = '0;
            failures    <= 0;
            answered    <= 0;
            waiting     <= 0;
            status_seen <= '0;
        end
        else
        begin
            if (hdr.valid && hdr.ready)
            begin
                expected_q.push_back(predict_dpb(hdr.codec_std, hdr.level_idc,
                                                 hdr.reorder_pictures, hdr.max_width,
                                                 hdr.max_height, hdr.pic_width,
                                                 hdr.pic_height, hdr.min_buffers,
                                                 hdr.view_count, hdr.interlaced));
            end
            if (res.valid && res.ready)
            begin
                status_mask[res.status] = 1'b1;
                if (expected_q.size() == 0)
                begin
                    fault_total++;
                    if (fault_total <= REPORT_MAX)
                        $display("[%0t] result word with nothing outstanding: %s=%0d status=%0d",
                                 $realtime, "num_pictures", res.num_pictures, res.status);
                end
                else
                begin
                    want = expected_q.pop_front();
                    answer_total++;
                    if (res.num_pictures !== want.num || res.status !== want.status)
                    begin
                        fault_total++;
                        if (fault_total <= REPORT_MAX)
                            $display({"[%0t] result word %0d: expected num_pictures=%0d ",
                                      "status=%0d, got num_pictures=%0d status=%0d"},
                                     $realtime, answer_total, want.num, want.status,
                                     res.num_pictures, res.status);
                    end
                end
            end
            failures    <= fault_total;
            answered    <= answer_total;
            waiting     <= expected_q.size();
            status_seen <= status_mask;
        end
    end

endmodule

`default_nettype wire

### sim/tb_top.sv
// Stimulus and verdict for the decoded picture buffer count block.
// Directed header words, then random ones under mixed idle/stall patterns.
// Depends on dpbc_pkg, dpbc_if, dpbc_scoreboard and the block itself.
`default_nettype none

module tb_top;
    import dpbc_pkg::*;

    localparam int unsigned RESET_CYCLES  = 9;
    localparam int unsigned PHASES        = 8;
    localparam int unsigned PHASE_WORDS   = 144;
    localparam int unsigned DRAIN_CYCLES  = 16;
    localparam int unsigned QUIET_LIMIT   = 2000;

    typedef struct packed {
        logic [STD_W-1:0]    codec;
        logic [LVL_W-1:0]    level;
        logic [REORD_W-1:0]  reorder;
        logic [DIM_W-1:0]    mw;
        logic [DIM_W-1:0]    mh;
        logic [DIM_W-1:0]    pw;
        logic [DIM_W-1:0]    ph;
        logic [MINBUF_W-1:0] minbuf;
        logic [VIEWS_W-1:0]  views;
        logic                ilace;
    } hdr_word_t;

    logic        clk;
    logic        rst_n;
    int unsigned send_idle_pct  = 0;
    int unsigned sink_stall_pct = 0;
    int unsigned words_sent     = 0;
    int unsigned directed_words = 0;

    int unsigned chk_failures;
    int unsigned chk_answered;
    int unsigned chk_waiting;
    logic [3:0]  chk_status_seen;

    dpbc_hdr_if hdr_ch ();
    dpbc_res_if res_ch ();

    decoded_picture_buffer_count dut (
        .clk   (clk),
        .rst_n (rst_n),
        .hdr   (hdr_ch),
        .res   (res_ch)
    );

    dpbc_scoreboard chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .hdr         (hdr_ch),
        .res         (res_ch),
        .failures    (chk_failures),
        .answered    (chk_answered),
        .waiting     (chk_waiting),
        .status_seen (chk_status_seen)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    always @(posedge clk)
    begin
        res_ch.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    function automatic hdr_word_t make_word(input logic [STD_W-1:0] codec,
                                            input int unsigned level, input int unsigned reorder,
                                            input int unsigned mw, input int unsigned mh,
                                            input int unsigned pw, input int unsigned ph,
                                            input int unsigned minbuf, input int unsigned views,
                                            input int unsigned ilace);
        hdr_word_t w;
        w.codec   = codec;
        w.level   = LVL_W'(level);
        w.reorder = REORD_W'(reorder);
        w.mw      = DIM_W'(mw);
        w.mh      = DIM_W'(mh);
        w.pw      = DIM_W'(pw);
        w.ph      = DIM_W'(ph);
        w.minbuf  = MINBUF_W'(minbuf);
        w.views   = VIEWS_W'(views);
        w.ilace   = ilace[0];
        return w;
    endfunction

    // returns at the edge where the word is taken
    task automatic drive_word(input hdr_word_t w);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            hdr_ch.valid <= 1'b0;
            @(posedge clk);
        end
        hdr_ch.valid            <= 1'b1;
        hdr_ch.codec_std        <= w.codec;
        hdr_ch.level_idc        <= w.level;
        hdr_ch.reorder_pictures <= w.reorder;
        hdr_ch.max_width        <= w.mw;
        hdr_ch.max_height       <= w.mh;
        hdr_ch.pic_width        <= w.pw;
        hdr_ch.pic_height       <= w.ph;
        hdr_ch.min_buffers      <= w.minbuf;
        hdr_ch.view_count       <= w.views;
        hdr_ch.interlaced       <= w.ilace;
        do
            @(posedge clk);
        while (!hdr_ch.ready);
        words_sent++;
    endtask

    // sender holds off until every outstanding result word is back
    task automatic wait_for_drain();
        hdr_ch.valid <= 1'b0;
        while (chk_answered != words_sent)
            @(posedge clk);
    endtask

    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((hdr_ch.valid && hdr_ch.ready) || (res_ch.valid && res_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no handshake for %0d cycles", QUIET_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin : stimulus
        hdr_word_t   w;
        int unsigned pick;
        rst_n                   <= 1'b0;
        hdr_ch.valid            <= 1'b0;
        hdr_ch.codec_std        <= STD_H264;
        hdr_ch.level_idc        <= '0;
        hdr_ch.reorder_pictures <= '0;
        hdr_ch.max_width        <= '0;
        hdr_ch.max_height       <= '0;
        hdr_ch.pic_width        <= '0;
        hdr_ch.pic_height       <= '0;
        hdr_ch.min_buffers      <= '0;
        hdr_ch.view_count       <= '0;
        hdr_ch.interlaced       <= 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // H.264: table lookup, zero-sized frame, clamped level split, reorder override
        drive_word(make_word(STD_H264,   0,  0,   176,   144, 0, 0,  0,  0, 0));
        drive_word(make_word(STD_H264,   9,  0,     0,   144, 0, 0,  0,  0, 0));
        drive_word(make_word(STD_H264, 255,  0,  1920,     0, 0, 0,  0,  0, 0));
        drive_word(make_word(STD_H264,  51,  0,  1920,  1088, 0, 0,  0,  1, 1));
        drive_word(make_word(STD_H264,  40,  0, 16383, 16383, 0, 0,  0,  0, 0));
        drive_word(make_word(STD_H264,  13, 31,     1,     1, 0, 0, 63, 31, 1));
        drive_word(make_word(STD_H264,  32, 16,    16,    16, 0, 0,  4,  2, 0));
        // HEVC: level out of range, missing limit, bad minor, top level
        drive_word(make_word(STD_HEVC,  29,  0, 0, 0,     0,     0,  5,  0, 0));
        drive_word(make_word(STD_HEVC, 187,  0, 0, 0,   100,   100, 32,  2, 0));
        drive_word(make_word(STD_HEVC, 255,  0, 0, 0,   100,   100, 63,  0, 1));
        drive_word(make_word(STD_HEVC,   0,  0, 0, 0,     0,     0,  0,  0, 0));
        drive_word(make_word(STD_HEVC,  30,  0, 0, 0,     0,     0,  0,  0, 0));
        drive_word(make_word(STD_HEVC,  33,  0, 0, 0,    64,    64,  0,  0, 0));
        drive_word(make_word(STD_HEVC,  39,  0, 0, 0,    64,    64,  0,  0, 0));
        drive_word(make_word(STD_HEVC,  66,  0, 0, 0,    64,    64,  3,  0, 0));
        drive_word(make_word(STD_HEVC, 186,  0, 0, 0, 16383, 16383,  0,  0, 0));
        // HEVC luma size exactly on and just past each threshold
        drive_word(make_word(STD_HEVC, 150,  0, 0, 0,  2048,  1088,  0,  0, 0));
        drive_word(make_word(STD_HEVC, 150,  0, 0, 0,  2048,  1089,  0,  0, 0));
        drive_word(make_word(STD_HEVC, 150,  0, 0, 0,  4096,  1088,  0,  0, 0));
        drive_word(make_word(STD_HEVC, 150,  0, 0, 0,  4096,  1089,  0,  0, 0));
        drive_word(make_word(STD_HEVC, 150,  0, 0, 0,  6144,  1088,  0,  0, 0));
        drive_word(make_word(STD_HEVC, 150,  0, 0, 0,  6144,  1089,  0,  0, 0));
        // JPEG and the unsupported standard
        drive_word(make_word(STD_JPEG, 255,  0, 0, 0,     0,     0,  7,  3, 1));
        drive_word(make_word(STD_JPEG,   0,  0, 0, 0,     0,     0,  0,  0, 0));
        drive_word(make_word(STD_NONE, 255, 31, 16383, 16383, 16383, 16383, 63, 31, 1));
        directed_words = words_sent;
        wait_for_drain();

        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase % 4)
                0:
                begin
                    send_idle_pct   = 0;
                    sink_stall_pct <= 0;
                end
                1:
                begin
                    send_idle_pct   = 55;
                    sink_stall_pct <= 0;
                end
                2:
                begin
                    send_idle_pct   = 0;
                    sink_stall_pct <= 55;
                end
                default:
                begin
                    send_idle_pct   = 20;
                    sink_stall_pct <= 20;
                end
            endcase
            for (int i = 0; i < PHASE_WORDS; i++)
            begin
                pick = $urandom_range(0, 9);
                w.codec = (pick < 4) ? STD_H264 : (pick < 8) ? STD_HEVC :
                          (pick == 8) ? STD_JPEG : STD_NONE;
                // mostly levels that hit the tables, some fully random
                if (w.codec == STD_HEVC && $urandom_range(0, 9) < 7)
                    w.level = LVL_W'(30 * $urandom_range(1, 6) + 3 * $urandom_range(0, 2)
                                     + $urandom_range(0, 2));
                else if (w.codec == STD_H264 && $urandom_range(0, 9) < 7)
                    w.level = LVL_W'(10 * $urandom_range(0, 5) + $urandom_range(0, 3));
                else
                    w.level = LVL_W'($urandom_range(0, 255));
                w.reorder = ($urandom_range(0, 1) == 0) ? '0 : REORD_W'($urandom_range(0, 31));
                // spread sizes over several octaves so every threshold gets hit
                w.mw = DIM_W'($urandom_range(0, (1 << $urandom_range(4, DIM_W)) - 1));
                w.mh = DIM_W'($urandom_range(0, (1 << $urandom_range(4, DIM_W)) - 1));
                w.pw = DIM_W'($urandom_range(0, (1 << $urandom_range(4, DIM_W)) - 1));
                w.ph = DIM_W'($urandom_range(0, (1 << $urandom_range(4, DIM_W)) - 1));
                w.minbuf = ($urandom_range(0, 4) != 0) ? MINBUF_W'($urandom_range(0, 16))
                                                      : MINBUF_W'($urandom_range(0, 63));
                w.views = ($urandom_range(0, 9) < 7) ? VIEWS_W'($urandom_range(0, 2))
                                                    : VIEWS_W'($urandom_range(0, 31));
                w.ilace = 1'($urandom_range(0, 1));
                drive_word(w);
            end
            wait_for_drain();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Covered %0d header words (%0d directed) across four idle/stall mixes.",
                 words_sent, directed_words);
        $display("Status codes returned (bit per code): %b; failures counted: %0d",
                 chk_status_seen, chk_failures + chk_waiting);
        if (chk_failures == 0 && chk_waiting == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire
